// ----- sv/resp_request_parser_core_assert.svh -----
// ---------------------------------------------------------------------------
// RESP request parser assertion macros
// Concurrent assertion wrappers for the parser's checker.
// ---------------------------------------------------------------------------
`ifndef RESP_REQUEST_PARSER_CORE_ASSERT_SVH
`define RESP_REQUEST_PARSER_CORE_ASSERT_SVH

// Assertion on an explicit clock and active-low disable.
`define RRP_ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Assertion on the block clock and reset.
`define RRP_ASSERT(label, prop, msg) \
    `RRP_ASSERT_CLK(label, aclk, aresetn, prop, msg)

`endif

// ----- sv/rrp_pkg.sv -----
// ---------------------------------------------------------------------------
// RESP request parser package
// Types, codes and limits shared by the parser modules.
// ---------------------------------------------------------------------------
`default_nettype none

package rrp_pkg;

    localparam int COUNT_WIDTH_DEF = 32;

    localparam int RES_FIFO_DEPTH = 4;
    localparam int RES_FIFO_PTR_W = $clog2(RES_FIFO_DEPTH);
    localparam int RES_FIFO_CNT_W = $clog2(RES_FIFO_DEPTH + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_ARRAY_LEN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_BULK_LEN      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_REQUEST_BYTES = 2'd2;

    localparam logic [15:0] MAX_ARRAY_LEN_RST     = 16'd1024;
    localparam logic [31:0] MAX_BULK_LEN_RST      = 32'd524288;
    localparam logic [31:0] MAX_REQUEST_BYTES_RST = 32'd1048576;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    localparam logic [2:0] KIND_BYTE   = 3'd0;
    localparam logic [2:0] KIND_ARGEND = 3'd1;
    localparam logic [2:0] KIND_DONE   = 3'd2;
    localparam logic [2:0] KIND_ERROR  = 3'd3;
    localparam logic [2:0] KIND_BIG    = 3'd4;

    typedef enum logic [8:0] {
        PH_ARR_MARK  = 9'b000000001,
        PH_ARR_DIG   = 9'b000000010,
        PH_ARR_LF    = 9'b000000100,
        PH_BULK_MARK = 9'b000001000,
        PH_BULK_DIG  = 9'b000010000,
        PH_BULK_LF   = 9'b000100000,
        PH_PAYLOAD   = 9'b001000000,
        PH_END_CR    = 9'b010000000,
        PH_END_LF    = 9'b100000000
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       flush;
    } req_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  payload_byte;
        logic [15:0] arg_index;
        logic [31:0] count_value;
        logic        last_of_run;
    } res_item_t;

    typedef struct packed {
        logic [15:0] max_array_len;
        logic [31:0] max_bulk_len;
        logic [31:0] max_request_bytes;
    } cfg_regs_t;

    typedef struct packed {
        phase_t      phase;
        logic [31:0] acc;
        logic        digit_seen;
        logic [15:0] args_total;
        logic [15:0] current_arg;
        logic [31:0] bulk_remaining;
        logic [31:0] bulk_length;
        logic        halted;
    } parse_state_t;

    typedef struct packed {
        logic [1:0] num;
        res_item_t  first;
        res_item_t  second;
    } step_res_t;

    function automatic parse_state_t clear_state();
        parse_state_t s;
        s       = '0;
        s.phase = PH_ARR_MARK;
        return s;
    endfunction

    function automatic res_item_t make_res(logic [2:0] kind, logic [7:0] pbyte,
                                           logic [15:0] idx, logic [31:0] cnt,
                                           logic last);
        res_item_t r;
        r.kind         = kind;
        r.payload_byte = pbyte;
        r.arg_index    = idx;
        r.count_value  = cnt;
        r.last_of_run  = last;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/resp_request_parser_core.sv -----
// ---------------------------------------------------------------------------
// RESP request parser core
// Parses array-of-bulk-strings requests, one byte per cycle unless stalled.
// ---------------------------------------------------------------------------
//  port group   direction  carries
//  s_*          in         request byte or flush (req_item_t)
//  m_*          out        payload byte, argument end, done, error (res_item_t)
//  cfg_wr_*     in         limit register writes, no wait
//
//  One request per cycle with queue room; results pass input register and queue.
//  Throughput is set by the combinational step logic and the result queue.
//  A byte ending the last argument yields two results, output one at a time.
//  Synchronous active-low reset clears parse state and queue, and resets limits.
//  Output stalls back-pressure the input once the queue cannot take two results.
// ---------------------------------------------------------------------------
`default_nettype none

module resp_request_parser_core
    import rrp_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  req_item_t             s_payload,
    output logic                  m_valid,
    input  logic                  m_ready,
    output res_item_t             m_payload,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    cfg_regs_t              cfg_reg;
    parse_state_t           state_reg, state_next;
    logic [COUNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic                   in_valid_reg;
    req_item_t              in_item_reg;
    step_res_t              step_res;
    logic                   room;
    logic                   advance;

    assign advance = in_valid_reg && room;
    assign s_ready = aresetn && (!in_valid_reg || advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_array_len     <= MAX_ARRAY_LEN_RST;
            cfg_reg.max_bulk_len      <= MAX_BULK_LEN_RST;
            cfg_reg.max_request_bytes <= MAX_REQUEST_BYTES_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_MAX_ARRAY_LEN:     cfg_reg.max_array_len     <= cfg_wr_data[15:0];
                REG_MAX_BULK_LEN:      cfg_reg.max_bulk_len      <= cfg_wr_data;
                REG_MAX_REQUEST_BYTES: cfg_reg.max_request_bytes <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_payload;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= clear_state();
            cnt_reg   <= '0;
        end else if (advance) begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    rrp_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .item   (in_item_reg),
        .st     (state_reg),
        .cnt    (cnt_reg),
        .cfg    (cfg_reg),
        .nx     (state_next),
        .nx_cnt (cnt_next),
        .res    (step_res)
    );

    rrp_res_fifo u_res_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_en   (advance),
        .push_res  (step_res),
        .room      (room),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

`default_nettype wire

// ----- sv/rrp_step.sv -----
// ---------------------------------------------------------------------------
// RESP request parser step logic
// Next parse state and results for one request byte or flush.
// ---------------------------------------------------------------------------
`default_nettype none

module rrp_step
    import rrp_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  req_item_t              item,
    input  parse_state_t           st,
    input  logic [COUNT_WIDTH-1:0] cnt,
    input  cfg_regs_t              cfg,
    output parse_state_t           nx,
    output logic [COUNT_WIDTH-1:0] nx_cnt,
    output step_res_t              res
);

    localparam int EXT_W = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;
    localparam int SUM_W = EXT_W + 2;

    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic [EXT_W-1:0]       cnt_ext;
    logic [EXT_W-1:0]       max_req_ext;
    logic [SUM_W-1:0]       total_sum;
    logic                   is_digit;
    logic [3:0]             digit_val;
    logic [35:0]            acc_next;
    logic [35:0]            hdr_limit;
    logic [15:0]            arg_inc;
    logic                   stop_en;
    logic [2:0]             stop_kind;
    logic [7:0]             b;

    assign b           = item.data_byte;
    assign cnt_inc     = (&cnt) ? cnt : cnt + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
    assign cnt_ext     = EXT_W'(cnt_inc);
    assign max_req_ext = EXT_W'(cfg.max_request_bytes);
    assign total_sum   = SUM_W'(cnt_ext) + SUM_W'(st.acc) + SUM_W'(2);
    assign is_digit    = (b >= CH_ZERO) && (b <= CH_NINE);
    assign digit_val   = 4'(b - CH_ZERO);
    assign acc_next    = 36'({st.acc, 3'b000}) + 36'({st.acc, 1'b0}) + 36'(digit_val);
    assign hdr_limit   = (st.phase == PH_ARR_DIG) ? 36'(cfg.max_array_len)
                                                  : 36'(cfg.max_bulk_len);
    assign arg_inc     = st.current_arg + 16'd1;

    always_comb begin
        nx        = st;
        nx_cnt    = cnt;
        res       = '0;
        stop_en   = 1'b0;
        stop_kind = KIND_ERROR;
        if (item.flush) begin
            nx     = clear_state();
            nx_cnt = '0;
        end else if (!st.halted) begin
            nx_cnt = cnt_inc;
            if (cnt_ext > max_req_ext) begin
                stop_en   = 1'b1;
                stop_kind = KIND_BIG;
            end else begin
                unique case (st.phase) inside
                    PH_ARR_MARK, PH_BULK_MARK: begin
                        if (b != ((st.phase == PH_ARR_MARK) ? CH_STAR : CH_DOLLAR)) begin
                            stop_en = 1'b1;
                        end else begin
                            nx.acc        = '0;
                            nx.digit_seen = 1'b0;
                            nx.phase      = (st.phase == PH_ARR_MARK) ? PH_ARR_DIG
                                                                      : PH_BULK_DIG;
                        end
                    end
                    PH_ARR_DIG, PH_BULK_DIG: begin
                        if (is_digit) begin
                            if (acc_next > hdr_limit) begin
                                stop_en   = 1'b1;
                                stop_kind = KIND_BIG;
                            end else begin
                                nx.acc        = acc_next[31:0];
                                nx.digit_seen = 1'b1;
                            end
                        end else if (b == CH_CR && st.digit_seen) begin
                            nx.phase = (st.phase == PH_ARR_DIG) ? PH_ARR_LF : PH_BULK_LF;
                        end else begin
                            stop_en = 1'b1;
                        end
                    end
                    PH_ARR_LF: begin
                        if (b != CH_LF) begin
                            stop_en = 1'b1;
                        end else if (st.acc[15:0] == 16'd0) begin
                            res.num   = 2'd1;
                            res.first = make_res(KIND_DONE, 8'd0, 16'd0, 32'd0, 1'b1);
                            nx        = clear_state();
                            nx_cnt    = '0;
                        end else begin
                            nx.args_total  = st.acc[15:0];
                            nx.current_arg = '0;
                            nx.phase       = PH_BULK_MARK;
                        end
                    end
                    PH_BULK_LF: begin
                        if (b != CH_LF) begin
                            stop_en = 1'b1;
                        end else if (st.acc > cfg.max_request_bytes ||
                                     total_sum > SUM_W'(cfg.max_request_bytes)) begin
                            stop_en   = 1'b1;
                            stop_kind = KIND_BIG;
                        end else begin
                            nx.bulk_length    = st.acc;
                            nx.bulk_remaining = st.acc;
                            nx.phase          = (st.acc == 32'd0) ? PH_END_CR : PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD: begin
                        res.num           = 2'd1;
                        res.first         = make_res(KIND_BYTE, b, st.current_arg, 32'd0,
                                                     1'b1);
                        nx.bulk_remaining = st.bulk_remaining - 32'd1;
                        if (st.bulk_remaining == 32'd1) begin
                            nx.phase = PH_END_CR;
                        end
                    end
                    PH_END_CR: begin
                        if (b != CH_CR) begin
                            stop_en = 1'b1;
                        end else begin
                            nx.phase = PH_END_LF;
                        end
                    end
                    PH_END_LF: begin
                        if (b != CH_LF) begin
                            stop_en = 1'b1;
                        end else if (arg_inc >= st.args_total) begin
                            res.num    = 2'd2;
                            res.first  = make_res(KIND_ARGEND, 8'd0, st.current_arg,
                                                  st.bulk_length, 1'b0);
                            res.second = make_res(KIND_DONE, 8'd0, 16'd0,
                                                  {16'd0, st.args_total}, 1'b1);
                            nx         = clear_state();
                            nx_cnt     = '0;
                        end else begin
                            res.num        = 2'd1;
                            res.first      = make_res(KIND_ARGEND, 8'd0, st.current_arg,
                                                      st.bulk_length, 1'b1);
                            nx.current_arg = arg_inc;
                            nx.phase       = PH_BULK_MARK;
                        end
                    end
                    default: begin
                        stop_en = 1'b1;
                    end
                endcase
            end
            if (stop_en) begin
                nx        = st;
                nx.halted = 1'b1;
                res.num   = 2'd1;
                res.first = make_res(stop_kind, 8'd0, st.current_arg, 32'd0, 1'b1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/rrp_res_fifo.sv -----
// ---------------------------------------------------------------------------
// RESP request parser result queue
// Small register queue taking up to two results per cycle, one out.
// ---------------------------------------------------------------------------
`default_nettype none

module rrp_res_fifo
    import rrp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push_en,
    input  step_res_t push_res,
    output logic      room,
    output logic      m_valid,
    input  logic      m_ready,
    output res_item_t m_payload
);

    res_item_t                 mem_reg [RES_FIFO_DEPTH];
    logic [RES_FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RES_FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RES_FIFO_CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]                push_num;
    logic                      pop;

    assign push_num  = push_en ? push_res.num : 2'd0;
    assign m_valid   = (cnt_reg != '0);
    assign m_payload = mem_reg[rd_ptr_reg];
    assign pop       = m_valid && m_ready;
    assign room      = (cnt_reg <= RES_FIFO_CNT_W'(RES_FIFO_DEPTH - 2));

    assign wr_ptr_next = wr_ptr_reg + RES_FIFO_PTR_W'(push_num);
    assign rd_ptr_next = rd_ptr_reg + RES_FIFO_PTR_W'(pop);
    assign cnt_next    = cnt_reg + RES_FIFO_CNT_W'(push_num) - RES_FIFO_CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_num != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push_res.first;
        end
        if (push_num == 2'd2) begin
            mem_reg[wr_ptr_reg + RES_FIFO_PTR_W'(1)] <= push_res.second;
        end
    end

endmodule

`default_nettype wire

// ----- sv/rrp_checker.sv -----
// ---------------------------------------------------------------------------
// RESP request parser checker
// Port-level assertions on the result channel, bound to the core.
// ---------------------------------------------------------------------------
`default_nettype none

`include "resp_request_parser_core_assert.svh"

module rrp_checker
    import rrp_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire res_item_t m_payload
);

    `RRP_ASSERT_CLK(a_reset_empties_out, aclk, 1'b1, !aresetn |=> !m_valid, "result valid after reset")
    `RRP_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_payload), "stalled result changed")
    `RRP_ASSERT(a_pair_follows, m_valid && m_ready && !m_payload.last_of_run |=> m_valid, "second result of a pair missing")
    `RRP_ASSERT(a_pair_is_done, m_valid && m_ready && !m_payload.last_of_run |=> m_payload.kind == KIND_DONE, "argument end not followed by done")

endmodule

bind resp_request_parser_core rrp_checker u_rrp_checker (.*);

`default_nettype wire

// ----- verif/tb_resp_request_parser_core.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// RESP request parser core testbench
// Streams request bytes and flushes through the parser under random
// back-pressure and idling, predicts every token it should emit (payload
// bytes, argument ends, completed commands, errors and oversize reports) and
// checks each emitted token in order against that prediction. Runs over
// several limit settings, the smallest and largest among them.
// ---------------------------------------------------------------------------

import rrp_pkg::*;

typedef enum {HDR_MORE, HDR_DONE, HDR_BAD, HDR_BIG} header_verdict_t;

class resp_token_board;
    logic [15:0]  lim_args;
    logic [31:0]  lim_bulk;
    logic [31:0]  lim_bytes;
    phase_t       phase;
    logic [31:0]  acc;
    bit           digit_seen;
    logic [15:0]  args_total;
    logic [15:0]  arg_now;
    logic [31:0]  bulk_left;
    logic [31:0]  bulk_len;
    logic [63:0]  cmd_bytes;
    bit           halted;
    res_item_t    awaited[$];
    int           faults;

    function new();
        lim_args  = MAX_ARRAY_LEN_RST;
        lim_bulk  = MAX_BULK_LEN_RST;
        lim_bytes = MAX_REQUEST_BYTES_RST;
        restart();
        halted = 1'b0;
        faults = 0;
    endfunction

    function void restart();
        phase      = PH_ARR_MARK;
        acc        = '0;
        digit_seen = 1'b0;
        args_total = '0;
        arg_now    = '0;
        bulk_left  = '0;
        bulk_len   = '0;
        cmd_bytes  = '0;
    endfunction

    function void set_limit(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_MAX_ARRAY_LEN:     lim_args  = data[15:0];
            REG_MAX_BULK_LEN:      lim_bulk  = data;
            REG_MAX_REQUEST_BYTES: lim_bytes = data;
            default: ;
        endcase
    endfunction

    function void emit(logic [2:0] kind, logic [7:0] pbyte, logic [15:0] idx,
                       logic [31:0] cnt, bit last);
        res_item_t r;
        r.kind         = kind;
        r.payload_byte = pbyte;
        r.arg_index    = idx;
        r.count_value  = cnt;
        r.last_of_run  = last;
        awaited.push_back(r);
    endfunction

    function void halt_with(logic [2:0] kind);
        emit(kind, 8'h00, arg_now, 32'd0, 1'b1);
        halted = 1'b1;
    endfunction

    function header_verdict_t header_digit(logic [7:0] b, logic [31:0] limit);
        logic [63:0] v;
        if (b >= CH_ZERO && b <= CH_NINE) begin
            v = {32'd0, acc} * 64'd10 + {56'd0, b - CH_ZERO};
            if (v > {32'd0, limit})
                return HDR_BIG;
            acc        = v[31:0];
            digit_seen = 1'b1;
            return HDR_MORE;
        end
        if (b == CH_CR && digit_seen)
            return HDR_DONE;
        return HDR_BAD;
    endfunction

    // Returns 0 when the request is swallowed by a halted parser.
    function bit note_request(req_item_t rq);
        logic [7:0]      b;
        logic [15:0]     next_arg;
        header_verdict_t hv;
        b = rq.data_byte;
        if (rq.flush) begin
            restart();
            halted = 1'b0;
            return 1'b1;
        end
        if (halted)
            return 1'b0;
        if (cmd_bytes < ((64'd1 << COUNT_WIDTH_DEF) - 64'd1))
            cmd_bytes++;
        if (cmd_bytes > {32'd0, lim_bytes}) begin
            halt_with(KIND_BIG);
            return 1'b1;
        end
        case (phase)
            PH_ARR_MARK: begin
                if (b != CH_STAR) begin
                    halt_with(KIND_ERROR);
                end else begin
                    acc        = '0;
                    digit_seen = 1'b0;
                    phase      = PH_ARR_DIG;
                end
            end
            PH_BULK_MARK: begin
                if (b != CH_DOLLAR) begin
                    halt_with(KIND_ERROR);
                end else begin
                    acc        = '0;
                    digit_seen = 1'b0;
                    phase      = PH_BULK_DIG;
                end
            end
            PH_ARR_DIG, PH_BULK_DIG: begin
                if (phase == PH_ARR_DIG)
                    hv = header_digit(b, {16'd0, lim_args});
                else
                    hv = header_digit(b, lim_bulk);
                case (hv)
                    HDR_BAD: halt_with(KIND_ERROR);
                    HDR_BIG: halt_with(KIND_BIG);
                    HDR_DONE: begin
                        if (phase == PH_ARR_DIG)
                            phase = PH_ARR_LF;
                        else
                            phase = PH_BULK_LF;
                    end
                    default: ;
                endcase
            end
            PH_ARR_LF: begin
                if (b != CH_LF) begin
                    halt_with(KIND_ERROR);
                end else begin
                    args_total = acc[15:0];
                    arg_now    = '0;
                    if (args_total == 16'd0) begin
                        emit(KIND_DONE, 8'h00, 16'd0, 32'd0, 1'b1);
                        restart();
                    end else begin
                        phase = PH_BULK_MARK;
                    end
                end
            end
            PH_BULK_LF: begin
                if (b != CH_LF) begin
                    halt_with(KIND_ERROR);
                end else begin
                    bulk_len = acc;
                    if (bulk_len > lim_bytes ||
                        cmd_bytes + {32'd0, bulk_len} + 64'd2 > {32'd0, lim_bytes}) begin
                        halt_with(KIND_BIG);
                    end else begin
                        bulk_left = bulk_len;
                        if (bulk_left == 32'd0)
                            phase = PH_END_CR;
                        else
                            phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                emit(KIND_BYTE, b, arg_now, 32'd0, 1'b1);
                bulk_left--;
                if (bulk_left == 32'd0)
                    phase = PH_END_CR;
            end
            PH_END_CR: begin
                if (b != CH_CR)
                    halt_with(KIND_ERROR);
                else
                    phase = PH_END_LF;
            end
            PH_END_LF: begin
                if (b != CH_LF) begin
                    halt_with(KIND_ERROR);
                end else begin
                    next_arg = arg_now + 16'd1;
                    if (next_arg >= args_total) begin
                        emit(KIND_ARGEND, 8'h00, arg_now, bulk_len, 1'b0);
                        emit(KIND_DONE, 8'h00, 16'd0, {16'd0, args_total}, 1'b1);
                        restart();
                    end else begin
                        emit(KIND_ARGEND, 8'h00, arg_now, bulk_len, 1'b1);
                        arg_now = next_arg;
                        phase   = PH_BULK_MARK;
                    end
                end
            end
            default: halt_with(KIND_ERROR);
        endcase
        return 1'b1;
    endfunction

    function void check_result(res_item_t got);
        res_item_t want;
        if (awaited.size() == 0) begin
            faults++;
            if (faults <= 30)
                $display("%0t: unexpected token, expected none, got kind %0d byte %02h",
                         $time, got.kind, got.payload_byte,
                         " arg %0d count %0d last %0b",
                         got.arg_index, got.count_value, got.last_of_run);
            return;
        end
        want = awaited.pop_front();
        if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
            got.arg_index !== want.arg_index || got.count_value !== want.count_value ||
            got.last_of_run !== want.last_of_run) begin
            faults++;
            if (faults <= 30)
                $display("%0t: token mismatch, expected kind %0d byte %02h arg %0d",
                         $time, want.kind, want.payload_byte, want.arg_index,
                         " count %0d last %0b, got kind %0d byte %02h arg %0d",
                         want.count_value, want.last_of_run, got.kind,
                         got.payload_byte, got.arg_index,
                         " count %0d last %0b", got.count_value, got.last_of_run);
        end
    endfunction

    function bit drained();
        return awaited.size() == 0;
    endfunction
endclass

module tb_resp_request_parser_core;

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    req_item_t             s_payload    = '0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    res_item_t             m_payload;
    logic                  cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data  = '0;

    resp_token_board board = new();

    logic [7:0]  cmd_q[$];
    int          burst_left    = 0;
    bit          steady        = 1'b0;
    int          steady_cmds   = 0;
    int          live_requests = 0;
    int          hold_asks     = 0;
    int          hold_served   = 0;
    int          hold_left     = 0;
    logic [15:0] rx_pattern    = 16'hFFFF;
    logic [5:0]  rx_tick       = '0;

    resp_request_parser_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_payload    (s_payload),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_payload    (m_payload),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    always #2 aclk = ~aclk;

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Token sink: check, then pick next ready from a long hold or the stall pattern.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result(m_payload);
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_asks != hold_served) begin
            hold_served = hold_asks;
            hold_left   = 300;
            m_ready <= 1'b0;
        end else begin
            if (rx_tick == 6'd0) begin
                case ($urandom_range(0, 3))
                    0: rx_pattern = 16'hFFFF;
                    1: rx_pattern = 16'($urandom_range(0, 16'hFFFF));
                    2: rx_pattern = 16'($urandom_range(0, 16'hFFFF) |
                                        $urandom_range(0, 16'hFFFF));
                    default: rx_pattern = 16'(($urandom_range(0, 16'hFFFF) &
                                               $urandom_range(0, 16'hFFFF)) | 1);
                endcase
            end
            m_ready <= rx_pattern[rx_tick[3:0]];
            rx_tick = rx_tick + 6'd1;
        end
    end

    task automatic push_req(input req_item_t it);
        if (!steady && burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 16);
        end
        if (burst_left > 0)
            burst_left--;
        s_valid   <= 1'b1;
        s_payload <= it;
        do @(posedge aclk); while (!s_ready);
        if (board.note_request(it))
            live_requests++;
    endtask

    task automatic send_cmd();
        req_item_t it;
        foreach (cmd_q[i]) begin
            it.data_byte = cmd_q[i];
            it.flush     = 1'b0;
            push_req(it);
        end
        cmd_q.delete();
    endtask

    task automatic send_flush();
        req_item_t it;
        it.data_byte = 8'($urandom_range(0, 255));
        it.flush     = 1'b1;
        push_req(it);
    endtask

    // Drop valid and wait until every predicted token has been seen.
    task automatic settle(input int extra);
        s_valid <= 1'b0;
        do @(posedge aclk); while (!board.drained());
        repeat (extra) @(posedge aclk);
    endtask

    task automatic program_limits(input logic [15:0] args, input logic [31:0] bulk,
                                  input logic [31:0] bytes);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= REG_MAX_ARRAY_LEN;
        cfg_wr_data  <= {16'd0, args};
        board.set_limit(REG_MAX_ARRAY_LEN, {16'd0, args});
        @(posedge aclk);
        cfg_wr_index <= REG_MAX_BULK_LEN;
        cfg_wr_data  <= bulk;
        board.set_limit(REG_MAX_BULK_LEN, bulk);
        @(posedge aclk);
        cfg_wr_index <= REG_MAX_REQUEST_BYTES;
        cfg_wr_data  <= bytes;
        board.set_limit(REG_MAX_REQUEST_BYTES, bytes);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            cmd_q.push_back(s[i]);
    endfunction

    function automatic void push_crlf();
        cmd_q.push_back(CH_CR);
        cmd_q.push_back(CH_LF);
    endfunction

    function automatic void push_number(input int v);
        if ($urandom_range(0, 7) == 0)
            push_text("00");
        push_text($sformatf("%0d", v));
    endfunction

    function automatic void compose_command(output bit broken);
        int         pick;
        int         nargs;
        int         len;
        int         cut;
        int         pos;
        logic [7:0] junk;
        cmd_q.delete();
        broken = 1'b0;
        pick   = $urandom_range(0, 99);
        if (pick >= 90) begin
            broken = 1'b1;
            if (pick < 95) begin
                if ($urandom_range(0, 1))
                    push_text("*");
                else begin
                    push_text("*1");
                    push_crlf();
                    push_text("$");
                end
                repeat ($urandom_range(1, 11))
                    cmd_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                if ($urandom_range(0, 1))
                    push_crlf();
            end else begin
                repeat ($urandom_range(1, 6))
                    cmd_q.push_back(8'($urandom_range(0, 255)));
            end
            return;
        end
        case ($urandom_range(0, 9))
            0:       nargs = 0;
            8, 9:    nargs = $urandom_range(4, 8);
            default: nargs = $urandom_range(1, 3);
        endcase
        push_text("*");
        push_number(nargs);
        push_crlf();
        repeat (nargs) begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
            push_text("$");
            push_number(len);
            push_crlf();
            repeat (len)
                cmd_q.push_back(8'($urandom_range(0, 255)));
            push_crlf();
        end
        if (pick >= 85) begin
            broken = 1'b1;
            cut    = $urandom_range(0, cmd_q.size() - 1);
            while (cmd_q.size() > cut)
                void'(cmd_q.pop_back());
        end else if (pick >= 70) begin
            broken = 1'b1;
            pos    = $urandom_range(0, cmd_q.size() - 1);
            case ($urandom_range(0, 3))
                0:       junk = 8'($urandom_range(0, 255));
                1:       junk = CH_CR;
                2:       junk = CH_LF;
                default: junk = $urandom_range(0, 1) ? CH_STAR : CH_DOLLAR;
            endcase
            cmd_q[pos] = junk;
        end
    endfunction

    task automatic run_random(input int quota, input int holds);
        int goal;
        int half;
        bit broken;
        goal = live_requests + quota;
        half = live_requests + quota / 2;
        while (live_requests < goal) begin
            if (holds > 0 && live_requests >= half) begin
                holds--;
                hold_asks++;
                steady      = 1'b1;
                steady_cmds = 8;
            end
            compose_command(broken);
            send_cmd();
            if (board.halted) begin
                repeat ($urandom_range(0, 3))
                    cmd_q.push_back(8'($urandom_range(0, 255)));
                send_cmd();
                send_flush();
            end else if (broken || $urandom_range(0, 9) == 0) begin
                send_flush();
            end
            if (steady) begin
                steady_cmds--;
                if (steady_cmds == 0)
                    steady = 1'b0;
            end else if ($urandom_range(0, 49) == 0) begin
                settle(0);
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty command, one extreme payload byte, wrong marker then halt,
        // CR without digits, oversize count, missing LF after payload
        push_text("*0");
        push_crlf();
        send_cmd();
        push_text("*1");
        push_crlf();
        push_text("$1");
        push_crlf();
        cmd_q.push_back(8'hFF);
        push_crlf();
        send_cmd();
        push_text("$*");
        send_cmd();
        send_flush();
        push_text("*");
        cmd_q.push_back(CH_CR);
        send_cmd();
        send_flush();
        push_text("*2000");
        send_cmd();
        send_flush();
        push_text("*1");
        push_crlf();
        push_text("$0");
        push_crlf();
        cmd_q.push_back(CH_CR);
        push_text("X");
        send_cmd();
        send_flush();

        run_random(350, 1);
        settle(8);
        program_limits(16'd3, 32'd5, 32'd40);
        run_random(300, 0);
        settle(8);
        program_limits(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_random(400, 1);
        settle(8);
        program_limits(16'd0, 32'd0, 32'd1);
        run_random(100, 0);
        settle(8);
        program_limits(16'd8, 32'd0, 32'd64);
        run_random(150, 0);
        settle(8);
        program_limits(16'd2, 32'd16, 32'd12);
        run_random(200, 0);
        settle(8);
        program_limits(16'd1024, 32'd100, 32'd200);
        run_random(300, 0);
        settle(8);

        if (board.faults == 0 && board.drained())
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
